FILE: design/amx_pkg.sv
// Package for the affine matrix inverse: divider item types and constants.
// No dependencies.
`default_nettype none
package amx_pkg;

  localparam int LANES = 6;
  localparam int QW    = 32;
  localparam int DW    = 64;

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW-1){1'b0}}};

  // One quotient lane: partial remainder, dividend bits shifting out / quotient
  // bits shifting in, early overflow and result sign.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lq;
    logic          ovf;
    logic          neg;
  } amx_lane_t;

  typedef struct packed {
    amx_lane_t [LANES-1:0] lane;
    logic [DW-1:0]         dmag;
    logic                  singular;
  } amx_div_t;

endpackage
`default_nettype wire

FILE: design/amx_front.sv
// Front stages: products, determinant and cofactors, magnitudes, dividend setup.
// Uses amx_pkg.
`default_nettype none
module amx_front import amx_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  input  wire logic signed [31:0] c_i,
  input  wire logic signed [31:0] d_i,
  input  wire logic signed [31:0] tx_i,
  input  wire logic signed [31:0] ty_i,
  input  wire logic [31:0]        eps_i,
  output logic                    out_valid_o,
  output amx_div_t                out_data_o,
  input  wire logic               out_ready_i
);

  localparam int NW = 64 + 2 * FRAC_BITS;
  localparam int HW = (NW - QW > DW) ? NW - QW : DW;

  typedef struct packed {
    logic signed [63:0] p_ad, p_bc, p_cty, p_dtx, p_btx, p_aty;
    logic signed [31:0] a, b, c, d;
  } s1_t;

  typedef struct packed {
    logic signed [63:0] det, ntx, nty;
    logic signed [31:0] a, b, c, d;
  } s2_t;

  typedef struct packed {
    logic [DW-1:0]         dmag;
    logic [3:0][31:0]      n32;
    logic [1:0][63:0]      n64;
    logic [LANES-1:0]      neg;
  } s3_t;

  logic [3:0] v_q;
  logic [3:0] take;
  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  amx_div_t s4_q, s4_d;

  assign take[3] = !v_q[3] || out_ready_i;
  assign take[2] = !v_q[2] || take[3];
  assign take[1] = !v_q[1] || take[2];
  assign take[0] = !v_q[0] || take[1];
  assign in_ready_o = take[0];

  always_comb begin
    s1_d.p_ad  = a_i * d_i;
    s1_d.p_bc  = b_i * c_i;
    s1_d.p_cty = c_i * ty_i;
    s1_d.p_dtx = d_i * tx_i;
    s1_d.p_btx = b_i * tx_i;
    s1_d.p_aty = a_i * ty_i;
    s1_d.a = a_i;
    s1_d.b = b_i;
    s1_d.c = c_i;
    s1_d.d = d_i;
  end

  always_comb begin
    s2_d.det = s1_q.p_ad - s1_q.p_bc;
    s2_d.ntx = s1_q.p_cty - s1_q.p_dtx;
    s2_d.nty = s1_q.p_btx - s1_q.p_aty;
    s2_d.a = s1_q.a;
    s2_d.b = s1_q.b;
    s2_d.c = s1_q.c;
    s2_d.d = s1_q.d;
  end

  always_comb begin
    logic dneg;
    dneg = s2_q.det[63];
    s3_d.dmag   = dneg ? 64'(-s2_q.det) : 64'(s2_q.det);
    s3_d.n32[0] = s2_q.d[31] ? 32'(-s2_q.d) : 32'(s2_q.d);
    s3_d.n32[1] = s2_q.b[31] ? 32'(-s2_q.b) : 32'(s2_q.b);
    s3_d.n32[2] = s2_q.c[31] ? 32'(-s2_q.c) : 32'(s2_q.c);
    s3_d.n32[3] = s2_q.a[31] ? 32'(-s2_q.a) : 32'(s2_q.a);
    s3_d.n64[0] = s2_q.ntx[63] ? 64'(-s2_q.ntx) : 64'(s2_q.ntx);
    s3_d.n64[1] = s2_q.nty[63] ? 64'(-s2_q.nty) : 64'(s2_q.nty);
    s3_d.neg[0] = s2_q.d[31] != dneg;
    s3_d.neg[1] = (!s2_q.b[31] && (s2_q.b != '0)) != dneg;
    s3_d.neg[2] = (!s2_q.c[31] && (s2_q.c != '0)) != dneg;
    s3_d.neg[3] = s2_q.a[31] != dneg;
    s3_d.neg[4] = s2_q.ntx[63] != dneg;
    s3_d.neg[5] = s2_q.nty[63] != dneg;
  end

  always_comb begin
    logic [NW-1:0] num;
    logic [HW-1:0] hi;
    num = '0;
    hi  = '0;
    s4_d.dmag     = s3_q.dmag;
    s4_d.singular = s3_q.dmag <= DW'(eps_i);
    for (int i = 0; i < LANES; i++) begin
      if (i < 4) begin
        num = NW'(s3_q.n32[i]) << (2 * FRAC_BITS);
      end else begin
        num = NW'(s3_q.n64[i-4]) << FRAC_BITS;
      end
      hi = HW'(num[NW-1:QW]);
      s4_d.lane[i].ovf = hi >= HW'(s3_q.dmag);
      s4_d.lane[i].rem = s4_d.lane[i].ovf ? '0 : hi[DW-1:0];
      s4_d.lane[i].lq  = num[QW-1:0];
      s4_d.lane[i].neg = s3_q.neg[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) v_q[0] <= in_valid_i;
      if (take[1]) v_q[1] <= v_q[0];
      if (take[2]) v_q[2] <= v_q[1];
      if (take[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) s1_q <= s1_d;
    if (take[1]) s2_q <= s2_d;
    if (take[2]) s3_q <= s3_d;
    if (take[3]) s4_q <= s4_d;
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = s4_q;

endmodule
`default_nettype wire

FILE: design/amx_div_step.sv
// One restoring-division step on all six quotient lanes, registered.
// Uses amx_pkg.
`default_nettype none
module amx_div_step import amx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire amx_div_t in_data_i,
  output logic          out_valid_o,
  output amx_div_t      out_data_o,
  input  wire logic     out_ready_i
);

  logic     v_q;
  amx_div_t data_q, data_d;

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    logic [DW:0] r2;
    logic        ge;
    r2 = '0;
    ge = 1'b0;
    data_d = in_data_i;
    for (int i = 0; i < LANES; i++) begin
      r2 = {in_data_i.lane[i].rem, in_data_i.lane[i].lq[QW-1]};
      ge = r2 >= {1'b0, in_data_i.dmag};
      if (ge) r2 = r2 - {1'b0, in_data_i.dmag};
      data_d.lane[i].rem = r2[DW-1:0];
      data_d.lane[i].lq  = {in_data_i.lane[i].lq[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) data_q <= data_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

FILE: design/amx_back.sv
// Output stage: sign, saturation and singular identity select, output register.
// Uses amx_pkg.
`default_nettype none
module amx_back import amx_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire amx_div_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0][31:0] coef_o,
  output logic             invertible_o,
  output logic             saturated_o
);

  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  logic             v_q;
  logic [5:0][31:0] coef_q, coef_d;
  logic             inv_q, inv_d;
  logic             sat_q, sat_d;

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    logic [QW-1:0] q;
    logic          s;
    q = '0;
    s = 1'b0;
    sat_d = 1'b0;
    inv_d = !in_data_i.singular;
    for (int i = 0; i < LANES; i++) begin
      q = in_data_i.lane[i].lq;
      if (in_data_i.lane[i].neg) begin
        s = in_data_i.lane[i].ovf || (q > NEG_MAG);
        coef_d[i] = s ? NEG_MAG : QW'(-q);
      end else begin
        s = in_data_i.lane[i].ovf || (q > POS_MAX);
        coef_d[i] = s ? POS_MAX : q;
      end
      sat_d = sat_d | s;
    end
    if (in_data_i.singular) begin
      coef_d = '0;
      coef_d[0] = ONE;
      coef_d[3] = ONE;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      coef_q <= coef_d;
      inv_q  <= inv_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o  = v_q;
  assign coef_o       = coef_q;
  assign invertible_o = inv_q;
  assign saturated_o  = sat_q;

endmodule
`default_nettype wire

FILE: design/affine_matrix_invert.sv
// Top level of the 2D affine matrix inverse (Q16.16 in, Q16.16 out).
// Uses amx_pkg, amx_front, amx_div_step, amx_back.
//
// Takes one matrix per cycle while in_ready_o is high and passes it through 37
// register stages: four front stages (products, determinant/cofactors,
// magnitudes, dividend setup), 32 restoring-division stages that produce one
// quotient bit each for all six coefficients, and one output register. Every
// stage holds its item when the next one is full and cannot take it, so a
// stalled output loses nothing and empty stages still fill. The user must write
// det_epsilon through det_epsilon_we_i only while no item is in flight; the
// block itself does not enforce this.
`default_nettype none
module affine_matrix_invert import amx_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               det_epsilon_we_i,
  input  wire logic [31:0]        det_epsilon_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  input  wire logic signed [31:0] c_i,
  input  wire logic signed [31:0] d_i,
  input  wire logic signed [31:0] tx_i,
  input  wire logic signed [31:0] ty_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      inv_a_o,
  output logic signed [31:0]      inv_b_o,
  output logic signed [31:0]      inv_c_o,
  output logic signed [31:0]      inv_d_o,
  output logic signed [31:0]      inv_tx_o,
  output logic signed [31:0]      inv_ty_o,
  output logic                    invertible_o,
  output logic                    saturated_o
);

  logic [31:0] eps_q;

  logic [QW:0]           v;
  logic [QW:0]           rdy;
  amx_div_t [QW:0]       data;
  logic [5:0][31:0]      coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 32'd4295;
    end else if (det_epsilon_we_i) begin
      eps_q <= det_epsilon_i;
    end
  end

  amx_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_i         (a_i),
    .b_i         (b_i),
    .c_i         (c_i),
    .d_i         (d_i),
    .tx_i        (tx_i),
    .ty_i        (ty_i),
    .eps_i       (eps_q),
    .out_valid_o (v[0]),
    .out_data_o  (data[0]),
    .out_ready_i (rdy[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    amx_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (v[k]),
      .in_ready_o  (rdy[k]),
      .in_data_i   (data[k]),
      .out_valid_o (v[k+1]),
      .out_data_o  (data[k+1]),
      .out_ready_i (rdy[k+1])
    );
  end

  amx_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (v[QW]),
    .in_ready_o   (rdy[QW]),
    .in_data_i    (data[QW]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coef_o       (coef),
    .invertible_o (invertible_o),
    .saturated_o  (saturated_o)
  );

  assign inv_a_o  = coef[0];
  assign inv_b_o  = coef[1];
  assign inv_c_o  = coef[2];
  assign inv_d_o  = coef[3];
  assign inv_tx_o = coef[4];
  assign inv_ty_o = coef[5];

endmodule
`default_nettype wire

FILE: design/amx_checker.sv
// Port-level checks for affine_matrix_invert, bound to the top level.
// No package dependency.
`default_nettype none
module amx_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] inv_a_i,
  input wire logic [31:0] inv_b_i,
  input wire logic [31:0] inv_c_i,
  input wire logic [31:0] inv_d_i,
  input wire logic [31:0] inv_tx_i,
  input wire logic [31:0] inv_ty_i,
  input wire logic        invertible_i,
  input wire logic        saturated_i
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inv_a_i) && $stable(inv_tx_i)
      && $stable(invertible_i) && $stable(saturated_i))
    else $error("result item changed while stalled");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !invertible_i |-> inv_a_i == ONE && inv_d_i == ONE && inv_b_i == '0
      && inv_c_i == '0 && inv_tx_i == '0 && inv_ty_i == '0)
    else $error("singular item is not the identity");

  a_sat_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> invertible_i)
    else $error("saturation flagged on singular item");

endmodule

bind affine_matrix_invert amx_checker #(.FRAC_BITS(FRAC_BITS)) u_amx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .inv_a_i      (inv_a_o),
  .inv_b_i      (inv_b_o),
  .inv_c_i      (inv_c_o),
  .inv_d_i      (inv_d_o),
  .inv_tx_i     (inv_tx_o),
  .inv_ty_i     (inv_ty_o),
  .invertible_i (invertible_o),
  .saturated_i  (saturated_o)
);
`default_nettype wire

FILE: verif/affine_matrix_invert_tb.sv
// Testbench for affine_matrix_invert: directed table plus random matrices,
// each result checked against a behavioral inverse computed here.
// Depends on amx_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module affine_matrix_invert_tb;
  import amx_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 37;

  typedef struct packed {
    logic signed [31:0] a, b, c, d, tx, ty;
  } matrix_t;

  typedef struct packed {
    logic signed [31:0] ia, ib, ic, id, itx, ity;
    logic               inv, sat;
  } inverse_t;

  typedef struct {
    matrix_t  m;
    bit       has_exp;
    inverse_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic det_epsilon_we_i = 1'b0;
  logic [31:0] det_epsilon_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] a_i = '0, b_i = '0, c_i = '0, d_i = '0, tx_i = '0, ty_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] inv_a_o, inv_b_o, inv_c_o, inv_d_o, inv_tx_o, inv_ty_o;
  logic invertible_o, saturated_o;

  logic [31:0] epsilon;
  inverse_t    pending_inverses[$];
  int          mismatches = 0;

  affine_matrix_invert #(.FRAC_BITS(FRAC)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("affine_matrix_invert regression: fail");
    $finish;
  end

  // signed (num * 2^sh) / den, truncated toward zero, saturated to 32 bits
  function automatic logic signed [31:0] div_sat(logic signed [127:0] num, int sh,
                                                 logic signed [127:0] den, ref bit sat);
    logic signed [127:0] q;
    q = (num <<< sh) / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic inverse_t invert(matrix_t m);
    inverse_t r;
    logic signed [127:0] det, mag, ntx, nty;
    bit sat;
    sat = 1'b0;
    det = 128'(m.a) * 128'(m.d) - 128'(m.b) * 128'(m.c);
    det = 128'(signed'(det[63:0]));
    mag = det < 0 ? -det : det;
    if (det == -128'sh8000000000000000) mag = 128'h8000000000000000;
    if (mag <= 128'(epsilon)) begin
      r = '0;
      r.ia = 32'sd1 <<< FRAC;
      r.id = 32'sd1 <<< FRAC;
      return r;
    end
    ntx = 128'(m.c) * 128'(m.ty) - 128'(m.d) * 128'(m.tx);
    nty = 128'(m.b) * 128'(m.tx) - 128'(m.a) * 128'(m.ty);
    ntx = 128'(signed'(ntx[63:0]));
    nty = 128'(signed'(nty[63:0]));
    r.ia  = div_sat(128'(m.d), 2 * FRAC, det, sat);
    r.ib  = div_sat(-128'(m.b), 2 * FRAC, det, sat);
    r.ic  = div_sat(-128'(m.c), 2 * FRAC, det, sat);
    r.id  = div_sat(128'(m.a), 2 * FRAC, det, sat);
    r.itx = div_sat(ntx, FRAC, det, sat);
    r.ity = div_sat(nty, FRAC, det, sat);
    r.inv = 1'b1;
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send(matrix_t m, bit has_exp, inverse_t exp, bit gaps);
    inverse_t p;
    p = invert(m);
    if (has_exp && p != exp) report("table row", 0, 0);
    if (gaps && $urandom_range(0, 3) == 0) idle_gap();
    in_valid_i <= 1'b1;
    {a_i, b_i, c_i, d_i, tx_i, ty_i} <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_inverses.push_back(p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [31:0] v);
    det_epsilon_we_i <= 1'b1;
    det_epsilon_i <= v;
    @(posedge clk_i);
    det_epsilon_we_i <= 1'b0;
    epsilon = v;
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 65535)) - 32'd32768;
      2: return (32'($urandom_range(0, 8)) << 16) * ($urandom_range(0, 1) ? 1 : -1);
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      4: return (32'sd1 <<< $urandom_range(0, 31));
      default: return 32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
    endcase
  endfunction

  always @(posedge clk_i) begin
    inverse_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_inverses.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        w = pending_inverses.pop_front();
        if (inv_a_o !== w.ia) report("inv_a", inv_a_o, w.ia);
        if (inv_b_o !== w.ib) report("inv_b", inv_b_o, w.ib);
        if (inv_c_o !== w.ic) report("inv_c", inv_c_o, w.ic);
        if (inv_d_o !== w.id) report("inv_d", inv_d_o, w.id);
        if (inv_tx_o !== w.itx) report("inv_tx", inv_tx_o, w.itx);
        if (inv_ty_o !== w.ity) report("inv_ty", inv_ty_o, w.ity);
        if (invertible_o !== w.inv) report("invertible", 32'(invertible_o), 32'(w.inv));
        if (saturated_o !== w.sat) report("saturated", 32'(saturated_o), 32'(w.sat));
      end
    end
  end

  // receiver stalls: mostly short, a few long, some stall-free stretches
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      out_ready_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  end

  localparam logic signed [31:0] ONE = 32'sh10000;

  initial begin
    row_t rows[$];
    inverse_t ident, none;
    matrix_t m;
    logic [31:0] eps_set[4];
    ident = '0;
    ident.ia = ONE;
    ident.id = ONE;
    none = '0;
    epsilon = 32'd4295;
    rows.push_back('{'{ONE, 0, 0, ONE, 0, 0}, 1, '{ONE, 0, 0, ONE, 0, 0, 1, 0}});
    rows.push_back('{'{0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000}, 1, ident});
    rows.push_back('{'{ONE, ONE, ONE, ONE, 5, 7}, 1, ident});
    rows.push_back('{'{1, 0, 0, 1, 0, 0}, 1, ident});
    rows.push_back('{'{32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0}, 0, none});
    rows.push_back('{'{32'sh80000000, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000},
                    0, none});
    rows.push_back('{'{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, -1, -1},
                    0, none});
    rows.push_back('{'{-ONE, 0, 0, -ONE, ONE, -ONE}, 1, '{-ONE, 0, 0, -ONE, ONE, -ONE, 1, 0}});
    rows.push_back('{'{0, ONE, ONE, 0, 3 * ONE, -2 * ONE}, 0, none});
    rows.push_back('{'{256, 0, 0, 256, 32'sh7fffffff, 32'sh80000000}, 0, none});
    rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 0, none});
    rows.push_back('{'{2 * ONE, ONE, 32'sh8000, 3 * ONE, 7, -9}, 0, none});
    rows.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh80000000, 32'sh7fffffff}, 0, none});
    rows.push_back('{'{100, 0, 0, 100, 0, 0}, 0, none});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send(rows[i].m, rows[i].has_exp, rows[i].exp, 1'b0);
    drain();
    eps_set = '{32'd0, 32'hffffffff, 32'd65536, 32'd4295};
    foreach (eps_set[k]) begin
      write_epsilon(eps_set[k]);
      send('{0, 0, 0, 0, 1, 1}, 0, none, 1'b0);
      send('{1, 0, 0, 1, 0, 0}, 0, none, 1'b0);
      send('{ONE, 0, 0, ONE, 0, 0}, 0, none, 1'b0);
      for (int i = 0; i < 430; i++) begin
        m = '{rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q()};
        if ($urandom_range(0, 9) == 0) begin
          m.c = m.a;
          m.d = m.b;
        end
        send(m, 0, none, 1'b1);
        if (i == 200) drain();
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("affine_matrix_invert regression: pass");
    end else begin
      $display("affine_matrix_invert regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
